[rtl/wtss_pkg.sv]
// Shared constants for the windowed track speed smoother.
// No dependencies; used by wtss_isqrt, the top level and the testbench.
`default_nettype none
package wtss_pkg;
   localparam int MAX_WINDOW_DEF = 512;
   localparam int POS_W          = 24;
   localparam int FRAME_W        = 32;
   localparam int SPEED_W        = 32;
   localparam int FR_W           = 16;
   localparam int UM_W           = 24;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UM_PER_PIXEL = 1'b1;
   localparam int RAD_W          = 50;        // dx^2+dy^2 padded to an even width
   localparam int ROOT_W         = RAD_W / 2;
   localparam int SPD_NUM_W      = 42;        // dist*rate + gap*128
   localparam int MUL_A_W        = 32;
   localparam int MUL_B_W        = 24;
   localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
   localparam int REQ_DATA_W     = 80;
   localparam int RSP_DATA_W     = 96;
endpackage
`default_nettype wire

[rtl/wtss_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on wtss_pkg for widths.
`default_nettype none
module wtss_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [wtss_pkg::RAD_W-1:0]    radicand,
   output logic                               done,
   output logic [wtss_pkg::ROOT_W-1:0]        root
);
   localparam int REM_W = wtss_pkg::ROOT_W + 3;
   localparam int CNT_W = $clog2(wtss_pkg::ROOT_W + 1);

   logic [wtss_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [wtss_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            cur, trial;

   always_comb begin
      cur     = {rem_ff[REM_W-3:0], rad_ff[wtss_pkg::RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(wtss_pkg::ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[wtss_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[wtss_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

[rtl/wtss_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wtss_pkg only through the instantiating module's width.
`default_nettype none
module wtss_div #(
   parameter int DIV_W = 42
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   input  wire logic [DIV_W-1:0] den,
   output logic                  done,
   output logic [DIV_W-1:0]      quot
);
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   cur;

   always_comb begin
      cur     = {rem_ff, quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cur >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(cur - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = cur[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

[rtl/windowed_track_speed_smoother_core.sv]
// Windowed track speed smoother: top level with sequencer, shared multiplier and window memory.
// Depends on wtss_pkg, wtss_isqrt and wtss_div.
//
// One tracked point is taken per request; each request gives exactly one response
// carrying the window-mean speed in pixels/s, in micrometres/s and the selected unit
// (all unsigned Q32.0). Requests are taken one at a time: req_tready is high only while
// the sequencer is idle, and a finished response may wait in its output register while
// the next request is taken. A lost point, a first point, an unknown rate or a
// non-positive frame gap goes straight to the output state and answers zeros. A normal
// point runs the shared multiplier four times (three when uncalibrated), the root unit
// for 25 iterations and the divider twice for DIV_W iterations each (42 at the default
// window); each evicted window entry adds a pass through ST_EVW and ST_EV. The window
// lives in two memories of MAX_WINDOW entries, each written at the tail slot and read at
// the window head; no clearing pass is needed, as only counted entries are ever read.
// Configuration (frame_rate, um_per_pixel) must be written by the user only while idle;
// the block itself does not enforce this.
`default_nettype none
module windowed_track_speed_smoother_core #(
   parameter int MAX_WINDOW = wtss_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pos_x [23:0], pos_y [47:24], frame_number [79:48]
   input  wire logic [wtss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // lost [0]
   input  wire logic                              req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // px_mean [31:0], um_mean [63:32], speed_sel [95:64]
   output logic [wtss_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [wtss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wtss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int HEAD_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = wtss_pkg::SPEED_W + HEAD_W;
   localparam int DIV_W  = (SUM_W + 1 > wtss_pkg::SPD_NUM_W) ? SUM_W + 1 : wtss_pkg::SPD_NUM_W;
   localparam int SW     = wtss_pkg::SPEED_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MX   = 4'd1;
   localparam logic [3:0] ST_MY   = 4'd2;
   localparam logic [3:0] ST_RT   = 4'd3;
   localparam logic [3:0] ST_RTW  = 4'd4;
   localparam logic [3:0] ST_MD   = 4'd5;
   localparam logic [3:0] ST_DV   = 4'd6;
   localparam logic [3:0] ST_DVW  = 4'd7;
   localparam logic [3:0] ST_FULL = 4'd8;
   localparam logic [3:0] ST_PUSH = 4'd9;
   localparam logic [3:0] ST_EVW  = 4'd10;
   localparam logic [3:0] ST_EV   = 4'd11;
   localparam logic [3:0] ST_MW   = 4'd12;
   localparam logic [3:0] ST_MU   = 4'd13;
   localparam logic [3:0] ST_MUR  = 4'd14;
   localparam logic [3:0] ST_OUT  = 4'd15;

   // configuration
   logic [wtss_pkg::FR_W-1:0] fr_ff;
   logic [wtss_pkg::UM_W-1:0] um_per_px_ff;

   // sequencer and point state
   logic [3:0]                    state_ff, state_in;
   logic                          have_prev_ff, have_prev_in;
   logic [wtss_pkg::POS_W-1:0]    prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [wtss_pkg::FRAME_W-1:0]  prev_frame_ff, prev_frame_in;
   logic [wtss_pkg::FRAME_W-1:0]  frame_ff, frame_in;
   logic [wtss_pkg::POS_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [30:0]                   gap_ff, gap_in;
   logic [wtss_pkg::MUL_P_W-1:0]  acc_ff, acc_in;
   logic [wtss_pkg::ROOT_W-1:0]   dist_ff, dist_in;
   logic [SW-1:0]                 spd_ff, spd_in;
   logic [SW-1:0]                 px_ff, px_in, um_ff, um_in;
   logic [HEAD_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wtss_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic [wtss_pkg::MUL_A_W-1:0]  mul_a;
   logic [wtss_pkg::MUL_B_W-1:0]  mul_b;
   logic [wtss_pkg::MUL_P_W-1:0]  prod_ff;

   // window memories
   logic [wtss_pkg::FRAME_W-1:0]  win_frames_mem [MAX_WINDOW];
   logic [SW-1:0]                 win_speeds_mem [MAX_WINDOW];
   logic [wtss_pkg::FRAME_W-1:0]  rd_frame_ff;
   logic [SW-1:0]                 rd_speed_ff;
   logic                          mem_we;
   logic [HEAD_W-1:0]             slot;
   logic [CNT_W:0]                slot_sum;

   // shared units
   logic                          sq_start, sq_done;
   logic [wtss_pkg::RAD_W-1:0]    sq_rad;
   logic [wtss_pkg::ROOT_W-1:0]   sq_root;
   logic                          dv_start, dv_done;
   logic [DIV_W-1:0]              dv_num, dv_den, dv_quot;

   // request fields
   logic [wtss_pkg::POS_W-1:0]    in_x, in_y;
   logic [wtss_pkg::FRAME_W-1:0]  in_frame, in_gap, age;
   logic                          req_acc;
   logic [16:0]                   win_raw;
   logic [CNT_W-1:0]              win;
   logic [HEAD_W-1:0]             head_next;
   logic                          can_load;

   assign in_x     = req_tdata[23:0];
   assign in_y     = req_tdata[47:24];
   assign in_frame = req_tdata[79:48];
   assign in_gap   = in_frame - prev_frame_ff;
   assign req_acc  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign age      = frame_ff - rd_frame_ff;
   assign head_next = (head_ff == HEAD_W'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
   assign slot_sum = {1'b0, CNT_W'(head_ff)} + {1'b0, count_ff};
   assign slot     = (slot_sum >= (CNT_W+1)'(MAX_WINDOW))
                     ? HEAD_W'(slot_sum - (CNT_W+1)'(MAX_WINDOW)) : HEAD_W'(slot_sum);
   assign can_load = !rsp_valid_ff || rsp_tready;

   // window length in frames: round(2*fps), clamped to 1..MAX_WINDOW-1
   always_comb begin
      win_raw = ({1'b0, fr_ff} + 17'd64) >> 7;
      if (win_raw == 17'd0)
         win = CNT_W'(1);
      else if (win_raw > 17'(MAX_WINDOW - 1))
         win = CNT_W'(MAX_WINDOW - 1);
      else
         win = CNT_W'(win_raw);
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_MX:   begin mul_a = 32'(dx_ff);   mul_b = dx_ff; end
         ST_MY:   begin mul_a = 32'(dy_ff);   mul_b = dy_ff; end
         ST_MD:   begin mul_a = 32'(dist_ff); mul_b = 24'(fr_ff); end
         default: begin mul_a = px_ff;        mul_b = um_per_px_ff; end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_frame_in = prev_frame_ff;
      frame_in      = frame_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      gap_in        = gap_ff;
      acc_in        = acc_ff;
      dist_in       = dist_ff;
      spd_in        = spd_ff;
      px_in         = px_ff;
      um_in         = um_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      sq_start      = 1'b0;
      sq_rad        = (wtss_pkg::RAD_W)'(acc_ff) + (wtss_pkg::RAD_W)'(prod_ff);
      dv_start      = 1'b0;
      dv_num        = DIV_W'(prod_ff) + DIV_W'({gap_ff, 7'd0});
      dv_den        = DIV_W'({gap_ff, 8'd0});
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               px_in    = '0;
               um_in    = '0;
               frame_in = in_frame;
               dx_in    = (in_x >= prev_x_ff) ? in_x - prev_x_ff : prev_x_ff - in_x;
               dy_in    = (in_y >= prev_y_ff) ? in_y - prev_y_ff : prev_y_ff - in_y;
               gap_in   = in_gap[30:0];
               state_in = ST_OUT;
               if (req_tuser) begin
                  // lost point: forget the track and empty the window
                  have_prev_in = 1'b0;
                  head_in      = '0;
                  count_in     = '0;
                  sum_in       = '0;
               end else begin
                  if (have_prev_ff && fr_ff != '0 && in_gap != '0 && !in_gap[31])
                     state_in = ST_MX;
                  have_prev_in  = 1'b1;
                  prev_x_in     = in_x;
                  prev_y_in     = in_y;
                  prev_frame_in = in_frame;
               end
            end
         end
         ST_MX:   state_in = ST_MY;
         ST_MY: begin
            acc_in   = prod_ff;
            state_in = ST_RT;
         end
         ST_RT: begin
            sq_start = 1'b1;
            state_in = ST_RTW;
         end
         ST_RTW: begin
            if (sq_done) begin
               dist_in  = sq_root;
               state_in = ST_MD;
            end
         end
         ST_MD:   state_in = ST_DV;
         ST_DV: begin
            dv_start = 1'b1;
            state_in = ST_DVW;
         end
         ST_DVW: begin
            if (dv_done) begin
               spd_in   = (|dv_quot[DIV_W-1:SW]) ? '1 : dv_quot[SW-1:0];
               state_in = ST_FULL;
            end
         end
         ST_FULL: begin
            // make room when all MAX_WINDOW slots are in use
            if (count_ff == CNT_W'(MAX_WINDOW)) begin
               sum_in   = sum_ff - SUM_W'(rd_speed_ff);
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(spd_ff);
            state_in = ST_EVW;
         end
         ST_EVW:  state_in = ST_EV;
         ST_EV: begin
            if (count_ff > CNT_W'(1) && !age[31] && age > 32'(win)) begin
               sum_in   = sum_ff - SUM_W'(rd_speed_ff);
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = ST_EVW;
            end else begin
               dv_start = 1'b1;
               dv_num   = DIV_W'(sum_ff) + DIV_W'(count_ff >> 1);
               dv_den   = DIV_W'(count_ff);
               state_in = ST_MW;
            end
         end
         ST_MW: begin
            if (dv_done) begin
               px_in    = dv_quot[SW-1:0];
               um_in    = dv_quot[SW-1:0];
               state_in = (um_per_px_ff != '0) ? ST_MU : ST_OUT;
            end
         end
         ST_MU:   state_in = ST_MUR;
         ST_MUR: begin
            acc_in   = prod_ff + wtss_pkg::MUL_P_W'(32768);
            um_in    = (|acc_in[wtss_pkg::MUL_P_W-1:48]) ? '1 : acc_in[47:16];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {um_ff, um_ff, px_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fr_ff         <= '0;
         um_per_px_ff  <= '0;
         have_prev_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_frame_ff <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_frame_ff <= prev_frame_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               wtss_pkg::CSR_FRAME_RATE:   fr_ff        <= csr_wdata[wtss_pkg::FR_W-1:0];
               wtss_pkg::CSR_UM_PER_PIXEL: um_per_px_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      frame_ff    <= frame_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      gap_ff      <= gap_in;
      acc_ff      <= acc_in;
      dist_ff     <= dist_in;
      spd_ff      <= spd_in;
      px_ff       <= px_in;
      um_ff       <= um_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= mul_a * mul_b;
   end

   // window memories: written at the tail slot, read at the head every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_frames_mem[slot] <= frame_ff;
         win_speeds_mem[slot] <= spd_ff;
      end
      rd_frame_ff <= win_frames_mem[head_ff];
      rd_speed_ff <= win_speeds_mem[head_ff];
   end

   wtss_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   wtss_div #(.DIV_W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

[rtl/wtss_checker.sv]
// Port-level checks for the windowed track speed smoother, bound to the top level.
// Depends on windowed_track_speed_smoother_core ports only.
`default_nettype none
module wtss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in work");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_sel_is_um: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95:64] == rsp_tdata[63:32])
      else $error("selected speed differs from micrometre speed");
   a_zero_px: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:0] == 32'd0 |-> rsp_tdata[63:32] == 32'd0)
      else $error("non-zero scaled speed for zero pixel speed");
endmodule

bind windowed_track_speed_smoother_core wtss_checker u_wtss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for windowed_track_speed_smoother_core: directed and random point requests,
// predicted in SystemVerilog and checked field by field. Depends on wtss_pkg and the RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_DEPTH = wtss_pkg::MAX_WINDOW_DEF;
   localparam int WATCHDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [wtss_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [wtss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [wtss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wtss_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   windowed_track_speed_smoother_core uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: configuration and tracker/window copies
   // ---------------------------------------------------------------------
   logic [15:0] rate_q;
   logic [23:0] um_scale_q;
   bit          prev_valid;
   logic [23:0] prev_x, prev_y;
   logic [31:0] prev_frame;
   logic [31:0] win_frame [WIN_DEPTH];
   logic [31:0] win_speed [WIN_DEPTH];
   int unsigned win_head, win_count;
   logic [63:0] win_sum;

   logic [wtss_pkg::RSP_DATA_W-1:0] speed_queue[$];
   int errors = 0;
   int n_requests = 0, n_responses = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int unsigned quiet_cycles = 0;

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic evict_oldest();
      win_sum -= win_speed[win_head];
      win_head = (win_head + 1) % WIN_DEPTH;
      win_count--;
   endtask

   // Advance the tracker by one point and return the expected response word
   task automatic track_point(input logic [23:0] x, input logic [23:0] y,
                              input logic [31:0] fr, input bit lost,
                              output logic [wtss_pkg::RSP_DATA_W-1:0] word);
      logic [63:0] px, um, dx, dy, root_len, spd;
      logic [31:0] gap, age;
      int unsigned win, slot;
      px = 0; um = 0;
      if (lost) begin
         prev_valid = 0;
         win_head = 0; win_count = 0; win_sum = 0;
      end else if (!prev_valid || rate_q == 0) begin
         prev_valid = 1;
         prev_x = x; prev_y = y; prev_frame = fr;
      end else begin
         gap = fr - prev_frame;
         if (gap != 0 && !gap[31]) begin
            dx = x >= prev_x ? x - prev_x : prev_x - x;
            dy = y >= prev_y ? y - prev_y : prev_y - y;
            root_len = int_root(dx * dx + dy * dy);
            spd = (root_len * rate_q + (64'(gap) << 7)) / (64'(gap) << 8);
            if (spd > 64'hFFFF_FFFF) spd = 64'hFFFF_FFFF;
            win = (rate_q + 64) >> 7;
            if (win < 1) win = 1;
            if (win > WIN_DEPTH - 1) win = WIN_DEPTH - 1;
            if (win_count >= WIN_DEPTH) evict_oldest();
            slot = (win_head + win_count) % WIN_DEPTH;
            win_frame[slot] = fr;
            win_speed[slot] = spd[31:0];
            win_count++;
            win_sum += spd;
            while (win_count > 1) begin
               age = fr - win_frame[win_head];
               if (age > win && !age[31]) evict_oldest();
               else break;
            end
            px = (win_sum + (win_count >> 1)) / win_count;
            if (um_scale_q != 0) begin
               um = (px * um_scale_q + 32768) >> 16;
               if (um > 64'hFFFF_FFFF) um = 64'hFFFF_FFFF;
            end else begin
               um = px;
            end
         end
         prev_x = x; prev_y = y; prev_frame = fr;
      end
      word = {um[31:0], um[31:0], px[31:0]};
   endtask

   // ---------------------------------------------------------------------
   // Request driver, response checker, receiver stalls, watchdog
   // ---------------------------------------------------------------------
   // tvalid stays high after a request is taken unless the sender idles or drains
   task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                             input logic [31:0] fr, input bit lost);
      logic [wtss_pkg::RSP_DATA_W-1:0] w;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tdata <= {fr, y, x};
      req_tuser <= lost;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_point(x, y, fr, lost, w);
      speed_queue.push_back(w);
      n_requests++;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      logic [wtss_pkg::RSP_DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_responses++;
         if (speed_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = speed_queue[0];
            speed_queue.delete(0);
            if (rsp_tdata[31:0] !== want[31:0]) begin
               $display("%0t: pixel speed expected %h actual %h", $time, want[31:0],
                        rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want[63:32]) begin
               $display("%0t: micrometre speed expected %h actual %h", $time,
                        want[63:32], rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== want[95:64]) begin
               $display("%0t: speed_sel expected %h actual %h", $time, want[95:64],
                        rsp_tdata[95:64]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stop sending, wait for every response, then let the clock run on before returning
   task automatic drain();
      req_tvalid <= 1'b0;
      while (speed_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic [wtss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [23:0] val);
      drain();
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == wtss_pkg::CSR_FRAME_RATE) rate_q = val[15:0];
      else um_scale_q = val;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Extremes, first point, unknown rate, gap zero/negative, lost, saturation
   task automatic test_directed();
      send_point(24'h0, 24'h0, 32'd5, 1'b0);             // first point, rate unknown
      send_point(24'hFFFFFF, 24'hFFFFFF, 32'd6, 1'b0);   // still unknown rate
      write_csr(wtss_pkg::CSR_FRAME_RATE, 24'h00FFFF);
      write_csr(wtss_pkg::CSR_UM_PER_PIXEL, 24'hFFFFFF);
      send_point(24'h0, 24'h0, 32'd7, 1'b0);             // max distance, saturation
      send_point(24'hFFFFFF, 24'h0, 32'd7, 1'b0);        // zero gap
      send_point(24'h0, 24'hFFFFFF, 32'd3, 1'b0);        // negative gap
      send_point(24'h000100, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(24'h000100, 24'hFFFFFF, 32'h0000_0010, 1'b0); // wrap, forward
      send_point(24'h123456, 24'h654321, 32'h0000_0011, 1'b1); // lost
      send_point(24'h123456, 24'h654321, 32'h0000_0012, 1'b0);
      send_point(24'h123400, 24'h654300, 32'h8000_0012, 1'b0); // gap = 2^31
      write_csr(wtss_pkg::CSR_FRAME_RATE, 24'h000001);   // minimum window
      write_csr(wtss_pkg::CSR_UM_PER_PIXEL, 24'h000000); // uncalibrated
      send_point(24'h0, 24'h0, 32'd100, 1'b0);
      send_point(24'h10, 24'h0, 32'd101, 1'b0);
      send_point(24'h20, 24'h20, 32'd102, 1'b0);
      send_point(24'h20, 24'h20, 32'd110, 1'b0);
      write_csr(wtss_pkg::CSR_FRAME_RATE, 24'h001E00);   // 30 fps
      write_csr(wtss_pkg::CSR_UM_PER_PIXEL, 24'h000001);
      for (int i = 0; i < 6; i++)
         send_point(24'(i * 300), 24'(i * 77), 32'(200 + i), 1'b0);
   endtask

   // Mostly well-formed tracks with random steps; some lost points and jumps
   task automatic test_random(input int count);
      logic [23:0] x, y;
      logic [31:0] fr;
      x = 24'($urandom); y = 24'($urandom); fr = $urandom;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0: send_point(24'($urandom), 24'($urandom), $urandom, 1'b1);
            1: begin
               x = 24'($urandom); y = 24'($urandom); fr = $urandom;
               send_point(x, y, fr, 1'b0);
            end
            2: send_point(24'($urandom), 24'($urandom), fr - $urandom_range(3), 1'b0);
            default: begin
               x = x + 24'($urandom_range(4095)) - 24'd2048;
               y = y + 24'($urandom_range(4095)) - 24'd2048;
               fr = fr + ($urandom_range(7) == 0 ? $urandom_range(400) : $urandom_range(1, 3));
               send_point(x, y, fr, 1'b0);
            end
         endcase
      end
   endtask

   task automatic test_settings(input int phase_items);
      logic [15:0] rates [4] = '{16'h0002, 16'h1900, 16'hFFFF, 16'h3C00};
      for (int k = 0; k < 4; k++) begin
         write_csr(wtss_pkg::CSR_FRAME_RATE, {8'h0, rates[k]});
         write_csr(wtss_pkg::CSR_UM_PER_PIXEL, k == 2 ? 24'h0 : 24'($urandom));
         test_random(phase_items);
      end
   endtask

   initial begin
      rate_q = 0; um_scale_q = 0; prev_valid = 0;
      prev_x = 0; prev_y = 0; prev_frame = 0;
      win_head = 0; win_count = 0; win_sum = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 29; recv_idle_pct = 78;
      test_directed();
      test_settings(80);
      send_idle_pct = 78; recv_idle_pct = 29;
      test_settings(80);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_settings(70);
      drain();
      $display("Covered %0d point requests and %0d responses across rate/scale extremes,",
               n_requests, n_responses);
      $display("lost points, wrapped and non-positive gaps and saturation.");
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
rtl/wtss_pkg.sv
rtl/wtss_isqrt.sv
rtl/wtss_div.sv
rtl/windowed_track_speed_smoother_core.sv
rtl/wtss_checker.sv
sim/tb.sv
